### src/sbmu_pkg.sv
package sbmu_pkg;

	localparam int MAX_SIDE = 16;
	localparam int MAX_DIMS = 16;
	localparam int LABEL_BITS = 8;

	localparam int OP_BITS = 2;
	localparam logic [OP_BITS-1:0] OP_WEIGHT = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LABEL = 2'd1;
	localparam logic [OP_BITS-1:0] OP_RECORD = 2'd2;
	localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] OUT_CORRECT = 2'd0;
	localparam logic [1:0] OUT_WRONG = 2'd1;
	localparam logic [1:0] OUT_UNLABELED = 2'd2;

	localparam int CNT_BITS = 20;
	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
	localparam int DIST_BITS = 36;

	localparam int REG_BITS = 5;
	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DIMS = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] neuron_row;
		logic [3:0] neuron_col;
		logic [3:0] element_index;
		logic signed [15:0] element_value;
		logic [7:0] class_label;
		logic record_last;
	} cmd_t;

	typedef struct packed {
		logic [3:0] bmu_row;
		logic [3:0] bmu_col;
		logic [7:0] bmu_label;
		logic [35:0] best_distance;
		logic [1:0] outcome;
		logic [19:0] records_seen;
		logic [19:0] error_total;
		logic [19:0] wrong_total;
		logic [19:0] unlabeled_total;
	} result_t;

endpackage

### src/som_bmu_label_classifier.sv
// A weight, label or clear word, or a non-last record element, is taken
// while idle and never raises busy. A last element starts a scan of H*W*D
// weight reads (one per cycle from the weight RAM), then drain, label read
// and score; done pulses in the cycle after score, with busy already low.
// One word is taken at a time; busy is high for the whole scan.
// Reset clears counts, registers to maximum, and the label valid bits.
module som_bmu_label_classifier
	import sbmu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cmd_t                cmd,
	output logic                done,
	output result_t             result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [REG_BITS-1:0] cfg_data
);
	localparam int SB = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int DB = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int NEUR = MAX_SIDE * MAX_SIDE;
	localparam int NB = $clog2(NEUR) > 0 ? $clog2(NEUR) : 1;
	localparam int WDEPTH = NEUR * MAX_DIMS;
	localparam int WB = $clog2(WDEPTH) > 0 ? $clog2(WDEPTH) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_LABEL = 3'd3;
	localparam logic [2:0] ST_SCORE = 3'd4;

	function automatic logic [REG_BITS-1:0] clampv(input logic [REG_BITS-1:0] v,
			input int top);
		logic [REG_BITS-1:0] t;
		t = REG_BITS'(top);
		if (v == '0) return REG_BITS'(1);
		if (v > t) return t;
		return v;
	endfunction

	logic [REG_BITS-1:0] width_q, height_q, dims_q;
	logic [2:0] state_q;
	logic [CNT_BITS-1:0] rec_q, err_q, wrong_q, unl_q;

	// scan indices
	logic [SB-1:0] r_q, c_q;
	logic [DB-1:0] d_q;
	logic [LABEL_BITS-1:0] rec_label_q;

	// pipeline: s1 = data read, s2 = squared difference
	logic v_s1, first_s1;
	logic [SB-1:0] r_s1, c_s1;
	logic [DB-1:0] d_s1;
	logic v_s2, last_s2, first_s2;
	logic [SB-1:0] r_s2, c_s2;
	logic [31:0] sq_s2;
	logic [DIST_BITS-1:0] acc_q, best_q;
	logic have_q;
	logic [SB-1:0] best_r_q, best_c_q;
	logic [LABEL_BITS-1:0] nlab;

	// weight RAM
	logic w_we;
	logic [WB-1:0] w_waddr, w_raddr;
	logic [15:0] w_rdata;
	// record RAM
	logic r_we;
	logic [DB-1:0] r_waddr, r_raddr;
	logic [15:0] r_rdata;
	// label RAM
	logic l_we;
	logic [NB-1:0] l_waddr, l_raddr;
	logic [LABEL_BITS-1:0] l_rdata;
	logic [NEUR-1:0] lvalid_q;
	logic lval_s;

	logic accept;
	logic addr_ok, elem_ok;
	logic [NB-1:0] cmd_neuron;
	logic last_step;

	assign accept = start && !busy;
	assign busy = state_q != ST_IDLE;
	assign addr_ok = (32'(cmd.neuron_row) < MAX_SIDE) && (32'(cmd.neuron_col) < MAX_SIDE);
	assign elem_ok = 32'(cmd.element_index) < MAX_DIMS;
	assign cmd_neuron = NB'(32'(cmd.neuron_row) * MAX_SIDE + 32'(cmd.neuron_col));

	assign w_we = accept && cmd.opcode == OP_WEIGHT && addr_ok && elem_ok;
	assign w_waddr = WB'(32'(cmd_neuron) * MAX_DIMS + 32'(cmd.element_index));
	assign w_raddr = WB'((32'(r_q) * MAX_SIDE + 32'(c_q)) * MAX_DIMS + 32'(d_q));
	assign r_we = accept && cmd.opcode == OP_RECORD && elem_ok;
	assign r_waddr = DB'(cmd.element_index);
	assign r_raddr = d_q;
	assign l_we = accept && cmd.opcode == OP_LABEL && addr_ok;
	assign l_waddr = cmd_neuron;
	assign l_raddr = NB'(32'(best_r_q) * MAX_SIDE + 32'(best_c_q));

	sbmu_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(cmd.element_value),
		.raddr(w_raddr), .rdata(w_rdata));
	sbmu_ram #(.WIDTH(16), .DEPTH(MAX_DIMS)) u_rram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(cmd.element_value),
		.raddr(r_raddr), .rdata(r_rdata));
	sbmu_ram #(.WIDTH(LABEL_BITS), .DEPTH(NEUR)) u_lram (
		.clk(clk), .we(l_we), .waddr(l_waddr),
		.wdata(cmd.class_label[LABEL_BITS-1:0]), .raddr(l_raddr), .rdata(l_rdata));

	assign last_step = (32'(d_q) == 32'(dims_q) - 1) && (32'(c_q) == 32'(width_q) - 1)
		&& (32'(r_q) == 32'(height_q) - 1);
	assign nlab = lval_s ? l_rdata : '0;

	// square of the difference, one multiplier
	logic signed [16:0] diff;
	logic [16:0] mag;
	assign diff = 17'(signed'(r_rdata)) - 17'(signed'(w_rdata));
	assign mag = diff[16] ? 17'(-diff) : diff;

	logic [DIST_BITS-1:0] dist_now;
	assign dist_now = (first_s2 ? '0 : acc_q) + DIST_BITS'(sq_s2);

	always_ff @(posedge clk) begin
		v_s1 <= state_q == ST_SCAN;
		first_s1 <= d_q == '0;
		r_s1 <= r_q;
		c_s1 <= c_q;
		d_s1 <= d_q;
		v_s2 <= v_s1;
		last_s2 <= (32'(d_s1) == 32'(dims_q) - 1);
		first_s2 <= first_s1;
		r_s2 <= r_s1;
		c_s2 <= c_s1;
		sq_s2 <= 32'(mag) * 32'(mag);
		if (v_s2) begin
			acc_q <= dist_now;
		end
		lval_s <= lvalid_q[l_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			width_q <= REG_BITS'(MAX_SIDE);
			height_q <= REG_BITS'(MAX_SIDE);
			dims_q <= REG_BITS'(MAX_DIMS);
			rec_q <= '0;
			err_q <= '0;
			wrong_q <= '0;
			unl_q <= '0;
			lvalid_q <= '0;
			r_q <= '0;
			c_q <= '0;
			d_q <= '0;
			have_q <= 1'b0;
			best_q <= '0;
			best_r_q <= '0;
			best_c_q <= '0;
			rec_label_q <= '0;
			done <= 1'b0;
			result <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH: width_q <= clampv(cfg_data, MAX_SIDE);
					REG_HEIGHT: height_q <= clampv(cfg_data, MAX_SIDE);
					REG_DIMS: dims_q <= clampv(cfg_data, MAX_DIMS);
					default: ;
				endcase
			end
			if (l_we) begin
				lvalid_q[l_waddr] <= 1'b1;
			end
			// compare on each neuron's final element
			if (v_s2 && last_s2) begin
				if (!have_q || dist_now < best_q) begin
					have_q <= 1'b1;
					best_q <= dist_now;
					best_r_q <= r_s2;
					best_c_q <= c_s2;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.opcode == OP_CLEAR) begin
							rec_q <= '0;
							err_q <= '0;
							wrong_q <= '0;
							unl_q <= '0;
						end else if (cmd.opcode == OP_RECORD && cmd.record_last) begin
							rec_label_q <= cmd.class_label[LABEL_BITS-1:0];
							r_q <= '0;
							c_q <= '0;
							d_q <= '0;
							have_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last_step) begin
						state_q <= ST_DRAIN;
					end else if (32'(d_q) == 32'(dims_q) - 1) begin
						d_q <= '0;
						if (32'(c_q) == 32'(width_q) - 1) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// wait until the last product lands
					if (v_s2 && !v_s1) begin
						state_q <= ST_LABEL;
					end
				end
				ST_LABEL: begin
					state_q <= ST_SCORE;
				end
				ST_SCORE: begin
					logic [CNT_BITS-1:0] rn, en, wn, un;
					logic [1:0] oc;
					rn = (rec_q == CNT_MAX) ? rec_q : rec_q + 1'b1;
					en = err_q;
					wn = wrong_q;
					un = unl_q;
					oc = OUT_CORRECT;
					if (nlab != rec_label_q) begin
						en = (err_q == CNT_MAX) ? err_q : err_q + 1'b1;
						if (nlab == '0) begin
							un = (unl_q == CNT_MAX) ? unl_q : unl_q + 1'b1;
							oc = OUT_UNLABELED;
						end else begin
							wn = (wrong_q == CNT_MAX) ? wrong_q : wrong_q + 1'b1;
							oc = OUT_WRONG;
						end
					end
					rec_q <= rn;
					err_q <= en;
					wrong_q <= wn;
					unl_q <= un;
					result.outcome <= oc;
					result.bmu_row <= 4'(best_r_q);
					result.bmu_col <= 4'(best_c_q);
					result.bmu_label <= 8'(nlab);
					result.best_distance <= best_q;
					result.records_seen <= rn;
					result.error_total <= en;
					result.wrong_total <= wn;
					result.unlabeled_total <= un;
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### src/sbmu_ram.sv
module sbmu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/sbmu_checker.sv
module sbmu_checker
	import sbmu_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input cmd_t    cmd,
	input logic    done,
	input result_t result
);
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_busy_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy during result");
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.opcode == OP_RECORD && cmd.record_last) |=> busy)
		else $error("scan did not start");
	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.outcome == OUT_CORRECT || result.outcome == OUT_WRONG
		|| result.outcome == OUT_UNLABELED)) else $error("bad outcome");
	a_err_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.error_total != CNT_MAX |-> result.error_total >=
		result.wrong_total) else $error("error count below wrong count");
endmodule

bind som_bmu_label_classifier sbmu_checker u_sbmu_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
	.done(done), .result(result));
